// File: hw/rtl/vcbl_pkg.sv
package vcbl_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_PITCH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT = 3'd4;

  localparam logic [5:0] LABEL_NONE = 6'h3F;

  typedef struct packed {
    logic [11:0] y;
    logic [11:0] x;
  } seed_t;

  typedef struct packed {
    logic [10:0] margin;
    logic [4:0]  pitch;
    logic [11:0] width;
    logic [11:0] height;
  } geom_t;

  // wide enough for the largest table the block supports
  typedef struct packed {
    logic       found;
    logic [7:0] idx;
  } owner_t;

endpackage

// File: hw/rtl/vcbl_seed_mem.sv
module vcbl_seed_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  vcbl_pkg::seed_t  wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output vcbl_pkg::seed_t  rd_data_r
);
  import vcbl_pkg::*;

  seed_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/vcbl_lane.sv
module vcbl_lane #(
  parameter int AW = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [10:0]      col,
  input  logic [10:0]      row,
  input  logic             ingrid,
  input  vcbl_pkg::geom_t  geom,
  input  logic             seed_vld,
  input  logic [AW-1:0]    seed_idx,
  input  vcbl_pkg::seed_t  seed,
  output vcbl_pkg::owner_t owner
);
  import vcbl_pkg::*;

  logic [15:0] px_w, py_w;
  logic        in_x, in_y;
  logic        ok_r;
  logic [11:0] px_r, py_r;

  logic signed [12:0] dx, dy;
  logic signed [25:0] sqx, sqy;
  logic [23:0]   sqx_r, sqy_r;
  logic          a_vld_r;
  logic [AW-1:0] a_idx_r;

  logic [24:0]   sq_dist;
  logic [24:0]   best_r;
  logic          found_r;
  logic [AW-1:0] best_idx_r;

  assign px_w = 16'(col) * 16'(geom.pitch);
  assign py_w = 16'(row) * 16'(geom.pitch);
  assign in_x = (px_w > 16'(geom.margin)) &&
                ((17'(px_w) + 17'(geom.margin)) < 17'(geom.width));
  assign in_y = (py_w > 16'(geom.margin)) &&
                ((17'(py_w) + 17'(geom.margin)) < 17'(geom.height));

  // inside the padded field the position fits in 12 bits; outside it the
  // distances are don't-care since ok_r masks the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (start) begin
      ok_r <= ingrid && in_x && in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px_r <= px_w[11:0];
      py_r <= py_w[11:0];
    end
  end

  assign dx  = $signed({1'b0, px_r}) - $signed({1'b0, seed.x});
  assign dy  = $signed({1'b0, py_r}) - $signed({1'b0, seed.y});
  assign sqx = dx * dx;
  assign sqy = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= seed_vld;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r   <= sqx[23:0];
    sqy_r   <= sqy[23:0];
    a_idx_r <= seed_idx;
  end

  assign sq_dist = 25'(sqx_r) + 25'(sqy_r);

  // seeds arrive in index order, strict compare keeps the lowest on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start) begin
      found_r <= 1'b0;
    end else if (a_vld_r && (!found_r || sq_dist < best_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld_r && (!found_r || sq_dist < best_r)) begin
      best_r     <= sq_dist;
      best_idx_r <= a_idx_r;
    end
  end

  assign owner.found = found_r && ok_r;
  assign owner.idx   = 8'(best_idx_r);

endmodule

// File: hw/rtl/voronoi_cell_boundary_labeler.sv
// Nearest-seed region labeler. Seeds are written into a table of MAX_SEEDS
// entries by load items (no result). A query item names a grid cell and
// returns its owner (nearest seed, lowest index on a tie, -1 outside the
// padded field or grid) and a boundary label (the owner when one of the
// four neighboring cells has a different owner, else -1). The cell and its
// four neighbors are evaluated side by side in five lanes while the seed
// table is streamed out of a single-port-read memory, one seed per cycle;
// a query's result is loaded into the result register after the setup,
// scan and drain states, and the next item can transfer once it is
// loaded. Only one query is in flight; the result register lets the next
// item transfer in while a result waits.
// Table entries must be written before a query that uses them.
module voronoi_cell_boundary_labeler #(
  parameter int MAX_SEEDS = 32,
  parameter int GRID_COLS = 1024,
  parameter int GRID_ROWS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [4:0]                       in_seed_slot,
  input  logic [11:0]                      in_seed_x,
  input  logic [11:0]                      in_seed_y,
  input  logic [9:0]                       in_cell_col,
  input  logic [9:0]                       in_cell_row,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [5:0]                out_owner_label,
  output logic signed [5:0]                out_edge_label,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vcbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [11:0]                      cfg_data
);
  import vcbl_pkg::*;

  localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW = $clog2(MAX_SEEDS + 1);
  localparam int NL = 5;
  localparam logic [12:0] GC = 13'(GRID_COLS);
  localparam logic [12:0] GR = 13'(GRID_ROWS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [5:0]  seed_count_r;
  geom_t       geom_r;

  logic [9:0]    col_r, row_r;
  logic [CW-1:0] n_r;
  logic [AW-1:0] rd_cnt_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic          drain_r;

  logic          in_xfer, load_xfer, query_xfer;
  logic [8:0]    slot_ext, sc_ext, n_ext;
  logic          rd_en, scan_last, out_load;
  seed_t         wr_seed, rd_seed;

  logic [10:0]   lane_col [NL];
  logic [10:0]   lane_row [NL];
  logic          lane_ok  [NL];
  owner_t        lane_own [NL];

  logic          c_zero, r_zero, differs;
  logic [10:0]   c_p1, c_m1, r_p1, r_m1;
  logic [5:0]    own_lbl;

  logic        out_valid_r;
  logic [5:0]  out_owner_r, out_edge_r;

  function automatic logic in_range(input logic [10:0] v, input logic [12:0] lim);
    in_range = (13'(v) < lim);
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r  <= 6'd20;
      geom_r.margin <= 11'd100;
      geom_r.pitch  <= 5'd2;
      geom_r.width  <= 12'd1024;
      geom_r.height <= 12'd768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEED_COUNT:   seed_count_r  <= cfg_data[5:0];
        REG_MARGIN:       geom_r.margin <= cfg_data[10:0];
        REG_CELL_PITCH:   geom_r.pitch  <= cfg_data[4:0];
        REG_FIELD_WIDTH:  geom_r.width  <= cfg_data;
        REG_FIELD_HEIGHT: geom_r.height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign load_xfer  = in_xfer && (in_command == CMD_LOAD);
  assign query_xfer = in_xfer && (in_command == CMD_QUERY);

  assign slot_ext  = 9'(in_seed_slot);
  assign wr_seed.x = in_seed_x;
  assign wr_seed.y = in_seed_y;

  assign sc_ext = 9'(seed_count_r);
  assign n_ext  = (sc_ext > 9'(MAX_SEEDS)) ? 9'(MAX_SEEDS) : sc_ext;

  always_ff @(posedge clk) begin
    if (query_xfer) begin
      col_r <= in_cell_col;
      row_r <= in_cell_row;
      n_r   <= CW'(n_ext);
    end
  end

  // table
  assign rd_en     = (state_r == ST_SCAN);
  assign scan_last = (CW'(rd_cnt_r) == (n_r - CW'(1)));

  vcbl_seed_mem #(
    .DEPTH (MAX_SEEDS),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (load_xfer && (slot_ext < 9'(MAX_SEEDS))),
    .wr_addr   (slot_ext[AW-1:0]),
    .wr_data   (wr_seed),
    .rd_en     (rd_en),
    .rd_addr   (rd_cnt_r),
    .rd_data_r (rd_seed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_cnt_r;
    if (state_r == ST_SETUP) begin
      rd_cnt_r <= '0;
      drain_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + AW'(1);
      end
      if (state_r == ST_DRAIN) begin
        drain_r <= 1'b1;
      end
    end
  end

  // lanes: center, north, east, south, west
  assign c_zero = (col_r == 10'd0);
  assign r_zero = (row_r == 10'd0);
  assign c_p1   = 11'(col_r) + 11'd1;
  assign c_m1   = 11'(col_r) - 11'd1;
  assign r_p1   = 11'(row_r) + 11'd1;
  assign r_m1   = 11'(row_r) - 11'd1;

  always_comb begin
    lane_col[0] = 11'(col_r); lane_row[0] = 11'(row_r);
    lane_col[1] = 11'(col_r); lane_row[1] = r_m1;
    lane_col[2] = c_p1;       lane_row[2] = 11'(row_r);
    lane_col[3] = 11'(col_r); lane_row[3] = r_p1;
    lane_col[4] = c_m1;       lane_row[4] = 11'(row_r);
    for (int k = 0; k < NL; k++) begin
      lane_ok[k] = in_range(lane_col[k], GC) && in_range(lane_row[k], GR);
    end
    if (r_zero) lane_ok[1] = 1'b0;
    if (c_zero) lane_ok[4] = 1'b0;
  end

  for (genvar k = 0; k < NL; k++) begin : g_lane
    vcbl_lane #(.AW(AW)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (state_r == ST_SETUP),
      .col      (lane_col[k]),
      .row      (lane_row[k]),
      .ingrid   (lane_ok[k]),
      .geom     (geom_r),
      .seed_vld (rd_vld_r),
      .seed_idx (rd_idx_r),
      .seed     (rd_seed),
      .owner    (lane_own[k])
    );
  end

  // control
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (query_xfer) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = (n_r == '0) ? ST_DRAIN : ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // boundary check on the five owners
  always_comb begin
    differs = 1'b0;
    for (int k = 1; k < NL; k++) begin
      if (lane_own[k].found != lane_own[0].found ||
          (lane_own[k].found && lane_own[k].idx != lane_own[0].idx)) begin
        differs = 1'b1;
      end
    end
  end

  assign own_lbl = lane_own[0].found ? 6'(lane_own[0].idx) : LABEL_NONE;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_owner_r <= own_lbl;
      out_edge_r  <= (lane_own[0].found && differs) ? own_lbl : LABEL_NONE;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_owner_label = $signed(out_owner_r);
  assign out_edge_label  = $signed(out_edge_r);

endmodule
